// ===== hdl/plt_pkg.sv =====
package plt_pkg;

    localparam int VA_W          = 16;
    localparam int OFFSET_W      = 8;
    localparam int PAGE_W        = 8;
    localparam int PA_W          = 15;
    localparam int FRAME_OUT_W   = 7;
    localparam int FRAME_NUM_DEF = 128;

    // update request from the top level to the cell row
    typedef struct packed {
        logic              upd;
        logic [PAGE_W-1:0] page;
    } t_ctl;

    // lookup status from the cell row
    typedef struct packed {
        logic              hit;
        logic [PAGE_W-1:0] victim_page;
    } t_stat;

endpackage

// ===== hdl/plt_cell.sv =====
module plt_cell
    import plt_pkg::*;
#(
    parameter int FW = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  logic              i_prev_valid,
    input  logic [FW-1:0]     i_prev_frame,
    input  logic [PAGE_W-1:0] i_prev_page,
    input  logic [PAGE_W-1:0] i_key_page,
    output logic              o_valid,
    output logic [FW-1:0]     o_frame,
    output logic [PAGE_W-1:0] o_page,
    output logic              o_match
);

    logic              r_valid;
    logic [FW-1:0]     r_frame;
    logic [PAGE_W-1:0] r_page;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_prev_valid;
        end
    end

    // payload: take the neighbor's entry on a shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_frame <= i_prev_frame;
            r_page  <= i_prev_page;
        end
    end

    assign o_valid = r_valid;
    assign o_frame = r_frame;
    assign o_page  = r_page;
    assign o_match = r_valid && (r_page == i_key_page);

endmodule

// ===== hdl/plt_chain.sv =====
module plt_chain
    import plt_pkg::*;
#(
    parameter int FRAME_NUM = FRAME_NUM_DEF,
    parameter int FW        = $clog2(FRAME_NUM)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ctl          i_ctl,
    input  logic          i_full,
    input  logic [FW-1:0] i_alloc_frame,
    output t_stat         o_stat,
    output logic [FW-1:0] o_frame
);

    localparam int LV = $clog2(FRAME_NUM);

    logic [FRAME_NUM-1:0] w_valid;
    logic [FRAME_NUM-1:0] w_match;
    logic [FW-1:0]        w_frame [FRAME_NUM];
    logic [PAGE_W-1:0]    w_page  [FRAME_NUM];
    logic [FRAME_NUM-1:0] w_stop;
    logic [FW-1:0]        w_hit_frame;
    logic [FW-1:0]        w_new_frame;
    logic                 w_hit;
    wire  [FRAME_NUM-1:0] w_pfx [0:LV];

    assign w_hit = |w_match;

    // frame of the matching cell
    always_comb begin
        w_hit_frame = '0;
        for (int i = 0; i < FRAME_NUM; i++) begin
            w_hit_frame = w_hit_frame | (w_match[i] ? w_frame[i] : '0);
        end
    end

    // hit: matching frame; miss: next free frame, or the oldest at the bottom
    always_comb begin
        if (w_hit) begin
            w_new_frame = w_hit_frame;
        end else if (i_full) begin
            w_new_frame = w_frame[FRAME_NUM-1];
        end else begin
            w_new_frame = i_alloc_frame;
        end
    end

    // cell where the shift ends
    always_comb begin
        for (int i = 0; i < FRAME_NUM; i++) begin
            if (w_hit) begin
                w_stop[i] = w_match[i];
            end else if (i_full) begin
                w_stop[i] = (i == FRAME_NUM - 1);
            end else begin
                w_stop[i] = (i_alloc_frame == FW'(i));
            end
        end
    end

    // suffix OR: the stop cell and every cell between it and the head shift
    assign w_pfx[0] = w_stop;
    for (genvar l = 0; l < LV; l++) begin : g_lvl
        for (genvar i = 0; i < FRAME_NUM; i++) begin : g_bit
            if (i + (1 << l) < FRAME_NUM) begin : g_or
                assign w_pfx[l+1][i] = w_pfx[l][i] | w_pfx[l][i+(1<<l)];
            end else begin : g_pass
                assign w_pfx[l+1][i] = w_pfx[l][i];
            end
        end
    end

    for (genvar i = 0; i < FRAME_NUM; i++) begin : g_cell
        logic              w_pv;
        logic [FW-1:0]     w_pf;
        logic [PAGE_W-1:0] w_pp;

        if (i == 0) begin : g_head
            assign w_pv = 1'b1;
            assign w_pf = w_new_frame;
            assign w_pp = i_ctl.page;
        end else begin : g_body
            assign w_pv = w_valid[i-1];
            assign w_pf = w_frame[i-1];
            assign w_pp = w_page[i-1];
        end

        plt_cell #(
            .FW (FW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (i_ctl.upd && w_pfx[LV][i]),
            .i_prev_valid (w_pv),
            .i_prev_frame (w_pf),
            .i_prev_page  (w_pp),
            .i_key_page   (i_ctl.page),
            .o_valid      (w_valid[i]),
            .o_frame      (w_frame[i]),
            .o_page       (w_page[i]),
            .o_match      (w_match[i])
        );
    end

    assign o_stat.hit         = w_hit;
    assign o_stat.victim_page = w_page[FRAME_NUM-1];
    assign o_frame            = w_new_frame;

endmodule

// ===== hdl/page_translate_lru_unit.sv =====
// Demand-paging address translator with exact LRU replacement. Each input word is a
// 16-bit virtual address: page in bits 15:8, offset in bits 7:0. A mapped page returns
// its frame; an unmapped page raises o_page_fault and takes the next never-used frame,
// or once all FRAME_NUM frames are handed out, the least recently used one, whose old
// page is reported on o_evicted_page and unmapped. Recency is kept in a row of
// FRAME_NUM cells ordered from most to least recently used: each cell holds a frame
// and the page it maps, all cells compare the page at once, and on every access the
// touched entry moves to the head while the cells above it shift down one place, so
// the bottom cell is always the eviction victim. The address is registered first;
// the cell row then compares and shifts, with the result landing in the output
// register at the end of that step; a new word is accepted only once the last one has
// left the row. The input may be accepted while a finished result waits in the output
// register, but the row does not advance until that register is free. No clearing pass
// follows reset.
module page_translate_lru_unit
    import plt_pkg::*;
#(
    parameter int FRAME_NUM = FRAME_NUM_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [VA_W-1:0]        i_virtual_address,
    // output channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [PA_W-1:0]        o_phys_addr,
    output logic [FRAME_OUT_W-1:0] o_frame_number,
    output logic [PAGE_W-1:0]      o_page_number,
    output logic                   o_page_fault,
    output logic                   o_evicted,
    output logic [PAGE_W-1:0]      o_evicted_page
);

    localparam int FW = $clog2(FRAME_NUM);
    localparam int CW = $clog2(FRAME_NUM + 1);

    logic                   r_work;
    logic [VA_W-1:0]        r_va;
    logic [CW-1:0]          r_used;
    logic                   r_out_valid;
    logic [PA_W-1:0]        r_pa;
    logic [FRAME_OUT_W-1:0] r_frame;
    logic [PAGE_W-1:0]      r_page;
    logic                   r_fault;
    logic                   r_evicted;
    logic [PAGE_W-1:0]      r_ev_page;

    logic                     w_accept;
    logic                     w_fire;
    logic                     w_full;
    logic [PAGE_W-1:0]        w_page;
    t_ctl                     w_ctl;
    t_stat                    w_stat;
    logic [FW-1:0]            w_frame;
    logic [FW+FRAME_OUT_W-1:0] w_frame_ext;
    logic [FRAME_OUT_W-1:0]   w_frame_out;

    // one word in flight; the row steps only when the output register is free
    assign w_accept = i_in_valid && !o_in_stall;
    assign w_fire   = r_work && (!r_out_valid || !i_out_stall);
    assign w_full   = (r_used == CW'(FRAME_NUM));
    assign w_page   = r_va[VA_W-1 -: PAGE_W];

    assign w_ctl.upd  = w_fire;
    assign w_ctl.page = w_page;

    plt_chain #(
        .FRAME_NUM (FRAME_NUM),
        .FW        (FW)
    ) u_chain (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_full        (w_full),
        .i_alloc_frame (r_used[FW-1:0]),
        .o_stat        (w_stat),
        .o_frame       (w_frame)
    );

    // fit the frame to the 7-bit result field: zero-extend or drop high bits
    assign w_frame_ext = {{FRAME_OUT_W{1'b0}}, w_frame};
    assign w_frame_out = w_frame_ext[FRAME_OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work      <= 1'b0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_work <= 1'b1;
            end else if (w_fire) begin
                r_work <= 1'b0;
            end
            // advance the fill count on a miss while free frames remain
            if (w_fire && !w_stat.hit && !w_full) begin
                r_used <= r_used + CW'(1);
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: capture address on accept, load result on a row step
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_va <= i_virtual_address;
        end
        if (w_fire) begin
            r_pa      <= {w_frame_out, r_va[OFFSET_W-1:0]};
            r_frame   <= w_frame_out;
            r_page    <= w_page;
            r_fault   <= !w_stat.hit;
            r_evicted <= !w_stat.hit && w_full;
            r_ev_page <= (!w_stat.hit && w_full) ? w_stat.victim_page : '0;
        end
    end

    assign o_in_stall     = r_work;
    assign o_out_valid    = r_out_valid;
    assign o_phys_addr    = r_pa;
    assign o_frame_number = r_frame;
    assign o_page_number  = r_page;
    assign o_page_fault   = r_fault;
    assign o_evicted      = r_evicted;
    assign o_evicted_page = r_ev_page;

endmodule

// ===== hdl/plt_checker.sv =====
module plt_checker
    import plt_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [PA_W-1:0]        o_phys_addr,
    input logic [PAGE_W-1:0]      o_page_number,
    input logic                   o_page_fault,
    input logic                   o_evicted,
    input logic [PAGE_W-1:0]      o_evicted_page
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_phys_addr))
        else $error("stalled result changed");

    // one word at a time: stall right after an accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // eviction only on a fault
    a_ev_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_evicted |-> o_page_fault)
        else $error("eviction without fault");

    // the victim page was mapped, so it cannot be the faulting page
    a_ev_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_evicted |-> o_evicted_page != o_page_number)
        else $error("evicted the requested page");

endmodule

bind page_translate_lru_unit plt_checker u_plt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_phys_addr    (o_phys_addr),
    .o_page_number  (o_page_number),
    .o_page_fault   (o_page_fault),
    .o_evicted      (o_evicted),
    .o_evicted_page (o_evicted_page)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

// Testbench for page_translate_lru_unit.
// Each word sent is a 16-bit virtual address. A behavioral page table sits beside the DUT:
// it maps pages to frames, hands out fresh frames in order, and evicts by exact LRU once
// all frames are taken. Every accepted address pushes one predicted translation. Every
// word the DUT delivers is compared field by field against the oldest prediction.
// Both channels idle at random. One phase holds the output stalled for a long stretch
// while addresses keep coming, so the DUT fills up and stalls its input.
module tb;
    import plt_pkg::*;

    localparam int FRAMES_TOTAL = FRAME_NUM_DEF;
    localparam int PAGE_COUNT   = 1 << PAGE_W;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_CAP    = 100;

    // one translated word, as the DUT presents it
    typedef struct packed {
        logic [PA_W-1:0]        pa;
        logic [FRAME_OUT_W-1:0] frame;
        logic [PAGE_W-1:0]      page;
        logic                   fault;
        logic                   ev;
        logic [PAGE_W-1:0]      ev_page;
    } t_xlate;

    // clock, reset and DUT ports; every input starts at a known value
    logic                   i_clk             = 1'b0;
    logic                   i_rst_n           = 1'b0;
    logic                   i_in_valid        = 1'b0;
    logic                   o_in_stall;
    logic [VA_W-1:0]        i_virtual_address = '0;
    logic                   o_out_valid;
    logic                   i_out_stall       = 1'b0;
    logic [PA_W-1:0]        o_phys_addr;
    logic [FRAME_OUT_W-1:0] o_frame_number;
    logic [PAGE_W-1:0]      o_page_number;
    logic                   o_page_fault;
    logic                   o_evicted;
    logic [PAGE_W-1:0]      o_evicted_page;

    // page table shadow: mapping, owners and recency stamps
    logic                   page_mapped [PAGE_COUNT] = '{default: 1'b0};
    logic [FRAME_OUT_W-1:0] page_map    [PAGE_COUNT];
    logic [PAGE_W-1:0]      frame_page  [FRAMES_TOTAL];
    logic [31:0]            frame_stamp [FRAMES_TOTAL];
    int                     frames_taken = 0;
    logic [31:0]            use_tick     = '0;

    t_xlate pending_xlate[$];
    int     mismatch_count = 0;
    int     cycle_count    = 0;
    int     out_wait       = 0;
    bit     no_idle        = 1'b0;   // zero gaps on both sides while set
    logic   hold_active    = 1'b0;
    event   hold_go;

    page_translate_lru_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_virtual_address (i_virtual_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_phys_addr       (o_phys_addr),
        .o_frame_number    (o_frame_number),
        .o_page_number     (o_page_number),
        .o_page_fault      (o_page_fault),
        .o_evicted         (o_evicted),
        .o_evicted_page    (o_evicted_page)
    );

    always #2 i_clk = ~i_clk;

    // Translate one address and advance the shadow page table. A hit reuses the mapped
    // frame; a fault takes the next fresh frame, or evicts the frame with the smallest
    // stamp (lowest index on a tie) and unmaps the page it held. Stamp on every access.
    function automatic t_xlate translate_address(input logic [VA_W-1:0] va);
        t_xlate                 r;
        logic [PAGE_W-1:0]      pg;
        logic [FRAME_OUT_W-1:0] fr;
        int                     oldest;
        pg = va[VA_W-1:OFFSET_W];
        r = '0;
        r.page = pg;
        if (page_mapped[pg]) begin
            fr = page_map[pg];
        end else begin
            r.fault = 1'b1;
            if (frames_taken >= FRAMES_TOTAL) begin
                oldest = 0;
                for (int i = 1; i < FRAMES_TOTAL; i++) begin
                    if (frame_stamp[i] < frame_stamp[oldest]) oldest = i;
                end
                fr = oldest[FRAME_OUT_W-1:0];
                r.ev = 1'b1;
                r.ev_page = frame_page[fr];
                page_mapped[frame_page[fr]] = 1'b0;
            end else begin
                fr = frames_taken[FRAME_OUT_W-1:0];
                frames_taken++;
            end
            page_mapped[pg] = 1'b1;
            page_map[pg]    = fr;
            frame_page[fr]  = pg;
        end
        frame_stamp[fr] = use_tick;
        use_tick        = use_tick + 1;
        r.frame = fr;
        r.pa    = {fr, va[OFFSET_W-1:0]};
        return r;
    endfunction

    // Print one line per mismatch up to a cap, count them all.
    task automatic report_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    endtask

    // Compare the word on the output port with the oldest pending translation.
    task automatic check_word();
        t_xlate want;
        if (pending_xlate.size() == 0) begin
            report_mismatch("output word with nothing pending", 0, o_phys_addr);
            return;
        end
        want = pending_xlate.pop_front();
        if (o_phys_addr !== want.pa)
            report_mismatch("phys_addr", want.pa, o_phys_addr);
        if (o_frame_number !== want.frame)
            report_mismatch("frame_number", want.frame, o_frame_number);
        if (o_page_number !== want.page)
            report_mismatch("page_number", want.page, o_page_number);
        if (o_page_fault !== want.fault)
            report_mismatch("page_fault", want.fault, o_page_fault);
        if (o_evicted !== want.ev)
            report_mismatch("evicted", want.ev, o_evicted);
        // the evicted page reads zero when nothing was evicted
        if (o_evicted_page !== want.ev_page)
            report_mismatch("evicted_page", want.ev_page, o_evicted_page);
    endtask

    // Output side: check each accepted word, then stall for a random number of cycles.
    // A long hold from the pressure phase overrides the random stalls.
    always @(posedge i_clk) begin
        logic took;
        int   w;
        took = i_rst_n && o_out_valid && !i_out_stall;
        if (took) check_word();
        if (hold_active) begin
            i_out_stall <= 1'b1;
        end else if (took) begin
            w = no_idle ? 0 : $urandom_range(0, 7);
            out_wait    <= w;
            i_out_stall <= (w != 0);
        end else if (out_wait > 0) begin
            out_wait    <= out_wait - 1;
            i_out_stall <= (out_wait > 1);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Long output hold, counted here so the sender keeps offering words meanwhile.
    initial begin
        forever begin
            @(hold_go);
            @(posedge i_clk);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active <= 1'b0;
        end
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one address after a random gap and hold it until accepted; predict on accept.
    // Leave valid high across back-to-back words so it never drops and rises in one step.
    task automatic send_address(input logic [VA_W-1:0] va);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_virtual_address <= va;
        do @(posedge i_clk); while (o_in_stall);
        pending_xlate.push_back(translate_address(va));
    endtask

    function automatic logic [VA_W-1:0] make_va(input logic [PAGE_W-1:0] pg);
        return {pg, 8'($urandom_range(0, 255))};
    endfunction

    // Field extremes, hits on the same page with other offsets, alternating bit patterns.
    task automatic test_directed();
        logic [VA_W-1:0] dir_va[$];
        dir_va = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h5AA5, 16'hA55A,
                   16'h5555, 16'hAAAA, 16'h0180, 16'h0001, 16'h8000, 16'h7FFF,
                   16'h55AA, 16'hAA55, 16'h0000, 16'hFFFF};
        foreach (dir_va[i]) send_address(dir_va[i]);
    endtask

    // Touch every page once in random order: fill all frames, then evict by LRU.
    task automatic test_fill_and_evict();
        logic [PAGE_W-1:0] order[$];
        for (int p = 0; p < PAGE_COUNT; p++) order.push_back(p[PAGE_W-1:0]);
        order.shuffle();
        foreach (order[i]) send_address(make_va(order[i]));
    endtask

    // Phases over working sets below, at and above the frame count, with some noise.
    task automatic test_working_sets();
        int                set_sizes[$];
        logic [PAGE_W-1:0] ws[$];
        set_sizes = '{8, 32, 100, 127, 128, 129, 160, 200};
        for (int ph = 0; ph < 9; ph++) begin
            ws.delete();
            repeat (set_sizes[$urandom_range(0, set_sizes.size() - 1)])
                ws.push_back(PAGE_W'($urandom_range(0, PAGE_COUNT - 1)));
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (80) begin
                if ($urandom_range(0, 9) == 0)
                    send_address(VA_W'($urandom));
                else
                    send_address(make_va(ws[$urandom_range(0, ws.size() - 1)]));
            end
        end
        no_idle = 1'b0;
    endtask

    // Stall the output for a long stretch while words keep coming back to back.
    task automatic test_backpressure();
        logic [PAGE_W-1:0] base;
        base    = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
        no_idle = 1'b1;
        -> hold_go;
        repeat (120) send_address(make_va(base + PAGE_W'($urandom_range(0, 47))));
        no_idle = 1'b0;
    endtask

    // Uniform addresses: mostly faults and evictions.
    task automatic test_uniform();
        repeat (200) send_address(VA_W'($urandom));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fill_and_evict();
        test_working_sets();
        test_backpressure();
        test_uniform();

        i_in_valid <= 1'b0;
        while (pending_xlate.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
